### hdl/hash_dedup_set_macros.svh
// assertion macros for the hash_dedup_set checker
`ifndef HASH_DEDUP_SET_MACROS_SVH
`define HASH_DEDUP_SET_MACROS_SVH

// implication in the same cycle, ignored while reset is applied
`define HDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle, ignored while reset is applied
`define HDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/hds_pkg.sv
// shared constants, types and helpers for the hash dedup set
`default_nettype none
package hds_pkg;

  // operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // splitmix64 finaliser constants
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int unsigned MIX_SH1 = 30;
  localparam int unsigned MIX_SH2 = 27;
  localparam int unsigned MIX_SH3 = 31;

  // memory port control from the probe sequencer
  typedef struct packed {
    logic rd;        // read key and used flag
    logic wr_key;    // write key entry
    logic wr_used;   // write used flag
    logic used_val;  // value of used flag to write
  } hds_mem_ctl_t;

  function automatic logic [63:0] mul_full(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] r;
    r = {32'd0, a} * {32'd0, b};
    return r;
  endfunction

  function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    r = a * b;
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/hds_hash.sv
// pipelined splitmix64 finaliser giving the home slot of a key
`default_nettype none
module hds_hash
  import hds_pkg::*;
#(
  parameter int OUT_W = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [63:0]      in_key,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_slot
);

  logic [4:0]       v_r;
  logic [63:0]      x1_r;
  logic [63:0]      p0a_r, p0b_r;
  logic [31:0]      p1a_r, p2a_r, p1b_r, p2b_r;
  logic [63:0]      y_r;
  logic [OUT_W-1:0] slot_r;
  logic [63:0]      m1, m2, hx;

  // 64x64 low product from three 32x32 partial products
  assign m1 = p0a_r + {p1a_r + p2a_r, 32'd0};
  assign m2 = p0b_r + {p1b_r + p2b_r, 32'd0};
  assign hx = m2 ^ (m2 >> MIX_SH3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    x1_r   <= in_key ^ (in_key >> MIX_SH1);
    p0a_r  <= mul_full(x1_r[31:0], MIX_C1[31:0]);
    p1a_r  <= mul_lo(x1_r[63:32], MIX_C1[31:0]);
    p2a_r  <= mul_lo(x1_r[31:0], MIX_C1[63:32]);
    y_r    <= m1 ^ (m1 >> MIX_SH2);
    p0b_r  <= mul_full(y_r[31:0], MIX_C2[31:0]);
    p1b_r  <= mul_lo(y_r[63:32], MIX_C2[31:0]);
    p2b_r  <= mul_lo(y_r[31:0], MIX_C2[63:32]);
    slot_r <= hx[OUT_W-1:0];
  end

  assign out_valid = v_r[4];
  assign out_slot  = slot_r;

endmodule
`default_nettype wire

### hdl/hds_table.sv
// slot memories: stored keys and used flags, registered read
`default_nettype none
module hds_table
  import hds_pkg::*;
#(
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire hds_mem_ctl_t      ctl,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [63:0]       wr_key,
  output logic [63:0]            rd_key,
  output logic                   rd_used
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [63:0] key_mem [DEPTH];
  logic        used_mem [DEPTH];
  logic [63:0] rd_key_r;
  logic        rd_used_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_key) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (ctl.rd) begin
      rd_key_r <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_used) begin
      used_mem[wr_addr] <= ctl.used_val;
    end
    if (ctl.rd) begin
      rd_used_r <= used_mem[rd_addr];
    end
  end

  assign rd_key  = rd_key_r;
  assign rd_used = rd_used_r;

endmodule
`default_nettype wire

### hdl/hash_dedup_set.sv
// top level of the hash dedup set: command port, probe sequencer and result register
`default_nettype none
// duplicate filter for 64-bit keys in a table of 2^LOG2_SLOTS slots with
// linear probing. a transaction is taken on a clock edge with start high and
// busy low; in_func selects insert (key scrambled by the splitmix64
// finaliser, low bits give the home slot) or clear of the whole set. every
// transaction gives exactly one result, shown for a single cycle with
// out_valid high; the receiver cannot stall it, so it must sample on that
// cycle. out_is_new marks a key stored now, out_full_res an insert that
// found every slot taken without the key, both low for a duplicate or clear.
// an insert first passes the five-stage multiplier pipeline of the hash,
// then probes slot after slot, each probe being a read of the slot memory
// and a check of the returned data; the result shows in the cycle after the
// last probe and busy is already low then. a clear sweeps the used-flag
// memory one slot a cycle. the same sweep runs after reset: busy stays high
// and no transaction is taken until it ends.
module hash_dedup_set
  import hds_pkg::*;
#(
  parameter int LOG2_SLOTS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic [63:0] in_key,
  output logic             out_valid,
  output logic             out_is_new,
  output logic             out_full_res
);

  // probe count that means every slot has been visited
  localparam logic [LOG2_SLOTS:0] SLOT_CNT = {1'b1, {LOG2_SLOTS{1'b0}}};

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_CHECK
  } state_t;

  state_t                state_r, state_nxt;
  logic [LOG2_SLOTS-1:0] pos_r, pos_nxt;     // slot under probe
  logic [LOG2_SLOTS-1:0] clr_r, clr_nxt;     // sweep address
  logic [LOG2_SLOTS:0]   n_r, n_nxt;         // slots probed so far
  logic                  clr_op_r, clr_op_nxt; // sweep came from a clear transaction
  logic [63:0]           key_r, key_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_is_new_r, out_is_new_nxt;
  logic                  out_full_r, out_full_nxt;

  logic                  accept;
  logic                  hash_valid;
  logic [LOG2_SLOTS-1:0] hash_slot;
  hds_mem_ctl_t          mem_ctl;
  logic [LOG2_SLOTS-1:0] wr_addr;
  logic [63:0]           rd_key;
  logic                  rd_used;
  logic [LOG2_SLOTS:0]   n_inc;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign n_inc  = n_r + 1'b1;

  // hash starts straight from the port on the accepting edge
  hds_hash #(
    .OUT_W (LOG2_SLOTS)
  ) u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept && (in_func == FUNC_INSERT)),
    .in_key    (in_key),
    .out_valid (hash_valid),
    .out_slot  (hash_slot)
  );

  // memory control: read in probe, write back on an empty slot, clear in sweep
  always_comb begin
    mem_ctl          = '0;
    mem_ctl.rd       = (state_r == ST_PROBE);
    mem_ctl.wr_key   = (state_r == ST_CHECK) && !rd_used;
    mem_ctl.wr_used  = (state_r == ST_CLR) || ((state_r == ST_CHECK) && !rd_used);
    mem_ctl.used_val = (state_r == ST_CHECK);
  end

  assign wr_addr = (state_r == ST_CLR) ? clr_r : pos_r;

  hds_table #(
    .ADDR_W (LOG2_SLOTS)
  ) u_table (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (pos_r),
    .wr_addr (wr_addr),
    .wr_key  (key_r),
    .rd_key  (rd_key),
    .rd_used (rd_used)
  );

  // probe sequencer
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    clr_nxt        = clr_r;
    n_nxt          = n_r;
    clr_op_nxt     = clr_op_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_is_new_nxt = 1'b0;
    out_full_nxt   = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = clr_op_r;
          clr_op_nxt    = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_CLEAR) begin
            state_nxt  = ST_CLR;
            clr_nxt    = '0;
            clr_op_nxt = 1'b1;
          end else begin
            state_nxt = ST_HASH;
            key_nxt   = in_key;
          end
        end
      end
      ST_HASH: begin
        if (hash_valid) begin
          state_nxt = ST_PROBE;
          pos_nxt   = hash_slot;
          n_nxt     = '0;
        end
      end
      ST_PROBE: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (!rd_used) begin
          // empty slot: key stored by the write above
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_is_new_nxt = 1'b1;
        end else if (rd_key == key_r) begin
          // duplicate
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else if (n_inc == SLOT_CNT) begin
          // every slot visited, key absent
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_full_nxt  = 1'b1;
        end else begin
          state_nxt = ST_PROBE;
          pos_nxt   = pos_r + 1'b1;
          n_nxt     = n_inc;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_r        <= '0;
      clr_op_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      out_is_new_r <= 1'b0;
      out_full_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      clr_op_r     <= clr_op_nxt;
      out_valid_r  <= out_valid_nxt;
      out_is_new_r <= out_is_new_nxt;
      out_full_r   <= out_full_nxt;
    end
    pos_r <= pos_nxt;
    n_r   <= n_nxt;
    key_r <= key_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_new   = out_is_new_r;
  assign out_full_res = out_full_r;

endmodule
`default_nettype wire

### hdl/hds_checker.sv
// port-level checker for the hash dedup set, bound to the top level
`default_nettype none
`include "hash_dedup_set_macros.svh"
module hds_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_is_new,
  input wire logic out_full_res
);

  // a stored key and a full table cannot both be reported
  `HDS_ASSERT_IMP(a_excl_res, clk, rst_n, out_valid, !(out_is_new && out_full_res), "new and full together")

  // result flags stay low between results
  `HDS_ASSERT_IMP(a_quiet, clk, rst_n, !out_valid, !out_is_new && !out_full_res, "flags without strobe")

  // a result closes the transaction, so the block is ready again
  `HDS_ASSERT_IMP(a_res_ready, clk, rst_n, out_valid, !busy && $past(busy), "result while busy")

  // an accepted transaction makes the block busy
  `HDS_ASSERT_NXT(a_take_busy, clk, rst_n, start && !busy, busy, "not busy after accept")

endmodule

bind hash_dedup_set hds_checker u_hds_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_is_new   (out_is_new),
  .out_full_res (out_full_res)
);
`default_nettype wire

### tb/hash_dedup_set_tb.sv
// self-checking testbench for the hash dedup set: shadow key table, random command traffic
`timescale 1ns / 100ps

module hash_dedup_set_tb
  import hds_pkg::*;
();

  localparam int LOG2_SLOTS = 10;
  localparam int SLOTS = 1 << LOG2_SLOTS;
  // far above the slowest legal run, which is dominated by the table fill
  // and by absent-key inserts on a full table (one whole lap each)
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // a full-table insert walks every slot, a read and a check for each
  localparam int unsigned SETTLE_CYCLES = 2 * SLOTS + 16;

  // what one transaction should produce on the result port
  typedef struct packed {
    logic is_new;
    logic full;
  } outcome_t;

  // shadow copy of the key table; predicts each outcome as commands are taken
  class dedup_shadow_t;
    logic [63:0] slot_key [SLOTS];
    bit          slot_taken [SLOTS];
    int unsigned occupied;
    outcome_t    answers [$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i] = '0;
        slot_taken[i] = 1'b0;
      end
      occupied = 0;
      mismatches = 0;
    endfunction

    // splitmix64 finaliser, low bits give the home slot
    function logic [LOG2_SLOTS-1:0] scramble_slot(logic [63:0] k);
      logic [63:0] m;
      m = k ^ (k >> 30);
      m = m * 64'hbf58476d1ce4e5b9;
      m = m ^ (m >> 27);
      m = m * 64'h94d049bb133111eb;
      m = m ^ (m >> 31);
      return m[LOG2_SLOTS-1:0];
    endfunction

    function int unsigned outstanding();
      return answers.size();
    endfunction

    // note one accepted command and queue the outcome it must give
    function void take_command(logic func, logic [63:0] k);
      outcome_t    o;
      int unsigned pos;
      bit          done;
      o = '0;
      if (func == FUNC_CLEAR) begin
        // used flags go, stored keys stay behind
        for (int i = 0; i < SLOTS; i++) slot_taken[i] = 1'b0;
        occupied = 0;
      end else begin
        pos = scramble_slot(k);
        done = 1'b0;
        for (int n = 0; n < SLOTS && !done; n++) begin
          if (!slot_taken[pos]) begin
            slot_key[pos] = k;
            slot_taken[pos] = 1'b1;
            occupied++;
            o.is_new = 1'b1;
            done = 1'b1;
          end else if (slot_key[pos] == k) begin
            done = 1'b1;
          end else begin
            pos = (pos + 1) % SLOTS;
          end
        end
        // one full lap without the key or a hole
        if (!done) o.full = 1'b1;
      end
      answers.insert(answers.size(), o);
    endfunction

    task report(string msg);
      if (mismatches < 50) $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_answer(logic is_new, logic full);
      outcome_t want;
      if (answers.size() == 0) begin
        report("result with no transaction outstanding");
      end else begin
        want = answers.pop_front();
        if (is_new !== want.is_new)
          report($sformatf("is_new %b, expected %b", is_new, want.is_new));
        if (full !== want.full)
          report($sformatf("full_res %b, expected %b", full, want.full));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = FUNC_INSERT;
  logic [63:0] in_key = '0;
  logic        out_valid;
  logic        out_is_new;
  logic        out_full_res;

  dedup_shadow_t shadow;
  logic [63:0]   sent_keys [$];
  int unsigned   burst_left = 0;
  int unsigned   cycles = 0;

  hash_dedup_set #(
    .LOG2_SLOTS(LOG2_SLOTS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_is_new  (out_is_new),
    .out_full_res(out_full_res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: a hung probe or a lost result ends the run here
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // monitor: take commands first so the prediction order follows acceptance,
  // then check any result shown in the cycle just ended
  always @(posedge clk) begin
    if (rst_n && shadow != null) begin
      if (start && busy === 1'b0) shadow.take_command(in_func, in_key);
      if (out_valid === 1'b1) shadow.check_answer(out_is_new, out_full_res);
    end
  end

  // gap before the next command: mostly none or short, a few long, and now
  // and then a burst of back-to-back commands
  function automatic int unsigned next_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // random key whose home slot is the one asked for
  function automatic logic [63:0] key_for_slot(int unsigned slot);
    logic [63:0] k;
    do k = {$urandom, $urandom}; while (shadow.scramble_slot(k) != slot);
    return k;
  endfunction

  // drive one transaction; entered and left on a falling edge
  task automatic issue(input logic func, input logic [63:0] key);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      start <= 1'b0;
      in_key <= {$urandom, $urandom};
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_key <= key;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    if (func == FUNC_INSERT) begin
      sent_keys.insert(sent_keys.size(), key);
      if (sent_keys.size() > 256) void'(sent_keys.pop_front());
    end
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (shadow.outstanding() != 0) @(negedge clk);
  endtask

  // general traffic: fresh keys, repeats, forced collisions, sparse keys, small
  // keys and the odd clear
  task automatic run_mix(input int unsigned count);
    int unsigned r;
    logic [63:0] k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55 || sent_keys.size() == 0) begin
        issue(FUNC_INSERT, {$urandom, $urandom});
      end else if (r < 75) begin
        issue(FUNC_INSERT, sent_keys[$urandom_range(0, sent_keys.size() - 1)]);
      end else if (r < 85) begin
        // same home slot as an earlier key, so the insert probes on if that key is still stored
        k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        issue(FUNC_INSERT, key_for_slot(shadow.scramble_slot(k)));
      end else if (r < 90) begin
        k = 64'd1 << $urandom_range(0, 63);
        issue(FUNC_INSERT, ($urandom_range(0, 1) != 0) ? ~k : k);
      end else if (r < 93) begin
        issue(FUNC_CLEAR, {$urandom, $urandom});
      end else begin
        issue(FUNC_INSERT, 64'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : stimulus
    logic [63:0] wrap_a;
    logic [63:0] wrap_b;
    logic [63:0] wrap_c;
    int unsigned r;
    shadow = new();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: key extremes, duplicates, wrap past the last slot, clears
    issue(FUNC_INSERT, 64'd0);
    issue(FUNC_INSERT, 64'd0);
    issue(FUNC_INSERT, '1);
    issue(FUNC_INSERT, 64'd1);
    issue(FUNC_INSERT, 64'h8000_0000_0000_0000);
    issue(FUNC_INSERT, '1);
    wrap_a = key_for_slot(SLOTS - 1);
    wrap_b = key_for_slot(SLOTS - 1);
    wrap_c = key_for_slot(SLOTS - 1);
    issue(FUNC_INSERT, wrap_a);
    issue(FUNC_INSERT, wrap_b);
    issue(FUNC_INSERT, wrap_c);
    issue(FUNC_INSERT, wrap_c);
    // home slot zero now sits behind the wrapped run
    issue(FUNC_INSERT, key_for_slot(0));
    issue(FUNC_CLEAR, '1);
    // stored keys survive a clear but must read as absent
    issue(FUNC_INSERT, 64'd0);
    issue(FUNC_INSERT, wrap_b);
    issue(FUNC_CLEAR, 64'd0);
    issue(FUNC_CLEAR, {$urandom, $urandom});
    issue(FUNC_INSERT, '1);
    issue(FUNC_INSERT, wrap_b);

    run_mix(250);
    wait_drained();

    // fill every slot, with some repeats mixed in
    issue(FUNC_CLEAR, {$urandom, $urandom});
    while (shadow.occupied < SLOTS) begin
      if ($urandom_range(0, 9) == 0 && sent_keys.size() != 0)
        issue(FUNC_INSERT, sent_keys[$urandom_range(0, sent_keys.size() - 1)]);
      else
        issue(FUNC_INSERT, {$urandom, $urandom});
    end

    // full table: absent keys give up after a lap, present keys are duplicates
    repeat (24) begin
      r = $urandom_range(0, 3);
      case (r)
        0: issue(FUNC_INSERT, {$urandom, $urandom});
        1: issue(FUNC_INSERT, shadow.slot_key[$urandom_range(0, SLOTS - 1)]);
        2: issue(FUNC_INSERT, 64'd0);
        default: issue(FUNC_INSERT, '1);
      endcase
    end
    wait_drained();

    issue(FUNC_CLEAR, {$urandom, $urandom});
    run_mix(80);

    // let the last results through, then watch for anything unasked for
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (shadow.outstanding() != 0)
      shadow.report($sformatf("%0d results never arrived", shadow.outstanding()));
    if (shadow.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/hds_pkg.sv
hdl/hds_hash.sv
hdl/hds_table.sv
hdl/hash_dedup_set.sv
hdl/hds_checker.sv
tb/hash_dedup_set_tb.sv
